FILE: rtl/tdd_pkg.sv
package tdd_pkg;

    localparam int ANCHOR_COUNT = 8;
    localparam int AW = (ANCHOR_COUNT > 1) ? $clog2(ANCHOR_COUNT) : 1;

    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 48;

    localparam int REC_W = 120;

    localparam logic [31:0] DIST_NUM = 32'd149896229;
    localparam logic [31:0] DIST_DEN = 32'd487500;
    localparam logic [63:0] DIST_HALF = 64'(DIST_DEN / 2);

    // metres scale split into a whole part and a remainder over the same divisor
    localparam logic [31:0] DIST_INT = DIST_NUM / DIST_DEN;
    localparam logic [31:0] DIST_FRAC = DIST_NUM - DIST_INT * DIST_DEN;
    // floor(2^50 / DIST_DEN)
    localparam logic [31:0] DIST_RECIP = 32'((64'd1 << 50) / 64'(DIST_DEN));

    localparam logic [39:0] SAT_MAX = 40'h7F_FFFF_FFFF;
    localparam logic [39:0] SAT_MIN = 40'h80_0000_0000;

    localparam logic [7:0] SEQ_MASK = 8'hFF;

endpackage

FILE: rtl/tdoa_distance_difference.sv
// tdoa distance difference, tag side of a two-way anchor scheme
// s_ channel: one word per slot of a received anchor packet; s_tlast marks the
//   final slot word of the packet, which starts the per-packet update
// m_ channel: at most one word per packet, the distance difference against
//   the anchor heard before, in signed q23.16 metres, saturated
// slot words that are not last leave s_tready high
// the last word of a packet holds s_tready low until the per-packet update is
//   done; the update is longest when it gives a result, shorter when a following
//   sequence number updates the ratio but the result is rejected, and shortest
//   otherwise: a 64-step restoring divider forms the clock ratio, the 32x32
//   multiplier is used six times, and ticks are scaled to metres by reciprocal
//   multiplication with one correction step
// words with an anchor id at or above the anchor count are taken and dropped
// reset clears the record valid bits at once, so every anchor record reads as
//   zero until its first packet; no clearing pass is needed
// if the receiver stalls, the result waits in the output register; the block
//   keeps taking slot words and only holds at the point where a new result
//   has to be stored
module tdoa_distance_difference (
    input  logic                            aclk,
    input  logic                            aresetn,
    // anchor_id, seq_nr, arrival_time, slot, slot_timestamp, slot_distance
    input  logic [tdd_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tlast,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // distance_diff, prev_anchor, curr_anchor
    output logic [tdd_pkg::M_TDATA_W-1:0]   m_tdata,
    // valid_res
    output logic                            m_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready
);
    import tdd_pkg::*;

    typedef enum logic [16:0] {
        S_IDLE  = 17'b00000000000000001,
        S_RDA   = 17'b00000000000000010,
        S_WAITA = 17'b00000000000000100,
        S_DIVR  = 17'b00000000000001000,
        S_CHK   = 17'b00000000000010000,
        S_RDP   = 17'b00000000000100000,
        S_WAITP = 17'b00000000001000000,
        S_MULD  = 17'b00000000010000000,
        S_MY    = 17'b00000000100000000,
        S_YL    = 17'b00000001000000000,
        S_RL    = 17'b00000010000000000,
        S_RH    = 17'b00000100000000000,
        S_QE    = 17'b00001000000000000,
        S_QD    = 17'b00010000000000000,
        S_FIX   = 17'b00100000000000000,
        S_OUT   = 17'b01000000000000000,
        S_WB    = 17'b10000000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [7:0]  s_aid;
    logic [7:0]  s_seq;
    logic [39:0] s_arr;
    logic [2:0]  s_slot;
    logic [39:0] s_sts;
    logic [31:0] s_sdist;

    assign s_aid   = s_tdata[7:0];
    assign s_seq   = s_tdata[15:8];
    assign s_arr   = s_tdata[55:16];
    assign s_slot  = s_tdata[58:56];
    assign s_sts   = s_tdata[98:59];
    assign s_sdist = s_tdata[130:99];

    // anchor records: {ratio, last_seq, last_arrival, own_tx}
    logic [REC_W-1:0] mem [ANCHOR_COUNT];
    logic [ANCHOR_COUNT-1:0] vld_reg;
    logic [REC_W-1:0] rd_data_reg;
    logic             rd_vld_reg;
    logic [AW-1:0]    rd_addr;
    logic [REC_W-1:0] rd_rec;
    logic [39:0]      rec_own_tx;
    logic [39:0]      rec_arr;
    logic [7:0]       rec_seq;
    logic [31:0]      rec_ratio;

    logic [AW-1:0] prev_anchor_reg;
    logic [39:0]   pkt_own_reg;
    logic [39:0]   pkt_prev_ts_reg;
    logic [31:0]   pkt_prev_dist_reg;

    logic [AW-1:0] cur_a_reg;
    logic [7:0]    cur_seq_reg;
    logic [39:0]   cur_arr_reg;
    logic          consec_reg;
    logic [31:0]   ratio_reg;

    logic [63:0] prod_reg;
    logic [31:0] mul_a, mul_b;
    logic [63:0] plo_reg;
    logic [33:0] mag_reg;
    logic        neg_reg;

    logic [49:0] y_reg;
    logic [63:0] base_reg;
    logic [31:0] q_reg;
    logic [63:0] m_reg;
    logic [95:0] q_sum;
    logic [49:0] rem_y;
    logic        fix_up;

    logic [63:0] div_num_reg;
    logic [32:0] div_rem_reg;
    logic [31:0] div_den_reg;
    logic [5:0]  div_cnt_reg;
    logic [32:0] div_rs;
    logic        div_ge;
    logic [63:0] div_q;
    logic        div_last;

    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tvalid_reg;

    logic        in_acc;
    logic        id_ok;
    logic        wb_go;
    logic [31:0] fa, ft, d_ticks;
    logic        consec;
    logic [32:0] delta;
    logic [33:0] pint;
    logic        ok;
    logic [39:0] dist_sat;
    logic        out_free;
    logic [7:0]  prev8, cur8;

    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign id_ok    = s_aid < 8'(ANCHOR_COUNT);
    assign out_free = !m_tvalid_reg || m_tready;

    assign rd_addr    = (state_reg == S_RDP) ? prev_anchor_reg : cur_a_reg;
    assign rd_rec     = rd_vld_reg ? rd_data_reg : '0;
    assign rec_own_tx = rd_rec[39:0];
    assign rec_arr    = rd_rec[79:40];
    assign rec_seq    = rd_rec[87:80];
    assign rec_ratio  = rd_rec[119:88];

    assign consec  = cur_seq_reg == ((rec_seq + 8'd1) & SEQ_MASK);
    assign fa      = 32'(pkt_own_reg - rec_own_tx);
    assign ft      = 32'(cur_arr_reg - rec_arr);
    assign d_ticks = 32'(cur_arr_reg - rec_arr);
    assign delta   = {1'b0, pkt_prev_dist_reg} + {1'b0, 32'(pkt_own_reg - pkt_prev_ts_reg)};
    assign pint    = prod_reg[63:30];

    assign ok = (cur_a_reg != prev_anchor_reg) && consec_reg && (pkt_prev_dist_reg != '0)
             && (pkt_prev_ts_reg != '0) && (ratio_reg != '0);

    assign prev8 = 8'(prev_anchor_reg);
    assign cur8  = 8'(cur_a_reg);

    // one restoring step a cycle
    assign div_rs   = {div_rem_reg[31:0], div_num_reg[63]};
    assign div_ge   = div_rs >= {1'b0, div_den_reg};
    assign div_q    = {div_num_reg[62:0], div_ge};
    assign div_last = div_cnt_reg == 6'd63;

    // quotient estimate is low by at most one, the remainder settles it
    assign q_sum  = {prod_reg, 32'b0} + {32'b0, plo_reg};
    assign rem_y  = y_reg - prod_reg[49:0];
    assign fix_up = rem_y >= 50'(DIST_DEN);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_WAITP: begin
                mul_a = d_ticks;
                mul_b = ratio_reg;
            end
            S_MY: begin
                mul_a = {1'b0, mag_reg[30:0]};
                mul_b = DIST_FRAC;
            end
            S_YL: begin
                mul_a = {1'b0, mag_reg[30:0]};
                mul_b = DIST_INT;
            end
            S_RL: begin
                mul_a = y_reg[31:0];
                mul_b = DIST_RECIP;
            end
            S_RH: begin
                mul_a = 32'(y_reg[49:32]);
                mul_b = DIST_RECIP;
            end
            S_QD: begin
                mul_a = q_reg;
                mul_b = DIST_DEN;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        if (!neg_reg) begin
            dist_sat = (m_reg > 64'(SAT_MAX)) ? SAT_MAX : m_reg[39:0];
        end else begin
            dist_sat = (m_reg > 64'(SAT_MIN)) ? SAT_MIN : 40'(-m_reg[39:0]);
        end
    end

    assign wb_go = (state_reg == S_OUT) && out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_acc && id_ok && s_tlast) state_next = S_RDA;
            S_RDA:   state_next = S_WAITA;
            S_WAITA: begin
                if (consec && ft != '0) state_next = S_DIVR;
                else                     state_next = S_CHK;
            end
            S_DIVR:  if (div_last) state_next = S_CHK;
            S_CHK:   state_next = ok ? S_RDP : S_WB;
            S_RDP:   state_next = S_WAITP;
            S_WAITP: state_next = S_MULD;
            S_MULD:  state_next = S_MY;
            S_MY:    state_next = S_YL;
            S_YL:    state_next = S_RL;
            S_RL:    state_next = S_RH;
            S_RH:    state_next = S_QE;
            S_QE:    state_next = S_QD;
            S_QD:    state_next = S_FIX;
            S_FIX:   state_next = S_OUT;
            // waits here until the output register is free
            S_OUT:   if (wb_go) state_next = S_WB;
            S_WB:    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            vld_reg           <= '0;
            prev_anchor_reg   <= '0;
            pkt_own_reg       <= '0;
            pkt_prev_ts_reg   <= '0;
            pkt_prev_dist_reg <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (wb_go) m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
            if (in_acc && id_ok) begin
                if ({5'b0, s_slot} == s_aid) pkt_own_reg <= s_sts;
                if ({5'b0, s_slot} == prev8) begin
                    pkt_prev_ts_reg   <= s_sts;
                    pkt_prev_dist_reg <= s_sdist;
                end
            end
            if (state_reg == S_WB) begin
                vld_reg[cur_a_reg] <= 1'b1;
                prev_anchor_reg    <= cur_a_reg;
                pkt_own_reg        <= '0;
                pkt_prev_ts_reg    <= '0;
                pkt_prev_dist_reg  <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
        rd_vld_reg  <= vld_reg[rd_addr];
        if (state_reg == S_WB) begin
            mem[cur_a_reg] <= {ratio_reg, cur_seq_reg, cur_arr_reg, pkt_own_reg};
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (in_acc && id_ok && s_tlast) begin
            cur_a_reg   <= s_aid[AW-1:0];
            cur_seq_reg <= s_seq;
            cur_arr_reg <= s_arr;
        end
        if (state_reg == S_WAITA) begin
            div_num_reg <= {2'b0, fa, 30'b0} + {33'b0, ft[31:1]};
            div_rem_reg <= '0;
            div_den_reg <= ft;
            div_cnt_reg <= '0;
        end else begin
            div_rem_reg <= div_ge ? (div_rs - {1'b0, div_den_reg}) : div_rs;
            div_num_reg <= div_q;
            div_cnt_reg <= div_cnt_reg + 6'd1;
        end
        case (state_reg)
            S_WAITA: begin
                consec_reg <= consec;
                ratio_reg  <= consec ? 32'd0 : rec_ratio;
            end
            S_DIVR: begin
                if (div_last) begin
                    ratio_reg <= (div_q[63:32] != '0) ? 32'hFFFF_FFFF : div_q[31:0];
                end
            end
            S_MULD: begin
                // product integer part against the expected delay
                if (pint >= {1'b0, delta}) begin
                    neg_reg <= 1'b0;
                    mag_reg <= pint - {1'b0, delta};
                end else begin
                    neg_reg <= 1'b1;
                    mag_reg <= {1'b0, delta} - pint - 34'(prod_reg[29:0] != '0);
                end
            end
            S_YL:  y_reg <= prod_reg[49:0] + DIST_HALF[49:0];
            S_RL:  base_reg <= prod_reg;
            S_RH:  plo_reg <= prod_reg;
            S_QE:  q_reg <= q_sum[81:50];
            S_QD:  base_reg <= base_reg + 64'(q_reg);
            S_FIX: begin
                // a magnitude of 2^31 ticks or more is past full scale
                if (mag_reg[33:31] != '0) m_reg <= '1;
                else m_reg <= base_reg + 64'(fix_up);
            end
            S_OUT: begin
                if (wb_go) m_tdata_reg <= {2'b0, cur8[2:0], prev8[2:0], dist_sat};
            end
            default: begin
            end
        endcase
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = 1'b1;
    assign m_tvalid = m_tvalid_reg;

`ifndef SYNTH
    a_prev_differs: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_RDP |-> cur_a_reg != prev_anchor_reg)
        else $error("distance path entered for the same anchor");

    a_ratio_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_WAITP |-> ratio_reg != '0)
        else $error("distance path with invalid clock ratio");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && m_tvalid_reg && !m_tready)
        |=> state_reg == S_OUT)
        else $error("result step moved on while output register full");
`endif

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import tdd_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [63:0] SAT_LIMIT = 64'h0000_007F_FFFF_FFFF;

    typedef struct {
        logic [S_TDATA_W-1:0] data;
        logic                 last;
    } slot_word_t;

    typedef struct {
        logic [39:0] diff;
        logic [2:0]  prev_a;
        logic [2:0]  curr_a;
    } dist_res_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   s_tlast = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;

    tdoa_distance_difference u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    slot_word_t word_q[$];
    dist_res_t  dist_q[$];
    int errors = 0;
    int words_sent = 0;
    int packets_sent = 0;
    int results_seen = 0;
    int cycles = 0;

    // predictor state, one record per anchor
    logic [39:0] tx_tab  [ANCHOR_COUNT];
    logic [39:0] arr_tab [ANCHOR_COUNT];
    logic [7:0]  seq_tab [ANCHOR_COUNT];
    logic [31:0] ratio_tab [ANCHOR_COUNT];
    logic [AW-1:0] heard_prev = '0;
    logic [39:0] pk_own = '0;
    logic [39:0] pk_prev_ts = '0;
    logic [31:0] pk_prev_dist = '0;

    initial begin
        for (int i = 0; i < ANCHOR_COUNT; i++) begin
            tx_tab[i] = '0;
            arr_tab[i] = '0;
            seq_tab[i] = '0;
            ratio_tab[i] = '0;
        end
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    function automatic logic [39:0] scale_to_metres(input logic [31:0] d, input logic [31:0] ratio,
                                                    input logic [63:0] delta);
        logic [63:0] prod, pint, mag, m;
        logic        neg;
        prod = 64'(d) * 64'(ratio);
        pint = prod >> 30;
        if (pint >= delta) begin
            neg = 1'b0;
            mag = pint - delta;
        end else begin
            neg = 1'b1;
            mag = delta - pint;
            if (prod[29:0] != 0) mag = mag - 1;
        end
        m = (mag * 64'(DIST_NUM) + DIST_HALF) / 64'(DIST_DEN);
        if (!neg) return (m > SAT_LIMIT) ? SAT_MAX : m[39:0];
        if (m > SAT_LIMIT + 1) return SAT_MIN;
        return 40'(-m);
    endfunction

    task automatic predict_word(input logic [S_TDATA_W-1:0] d, input logic lst);
        logic [7:0]  aid, seq;
        logic [39:0] arr, sts;
        logic [2:0]  slot;
        logic [31:0] sdist, fa, ft, dd;
        logic [63:0] q, delta;
        logic [AW-1:0] a, p;
        logic        consec;
        dist_res_t   r;
        aid = d[7:0];
        seq = d[15:8];
        arr = d[55:16];
        slot = d[58:56];
        sts = d[98:59];
        sdist = d[130:99];
        if (aid >= ANCHOR_COUNT) return;
        a = aid[AW-1:0];
        p = heard_prev;
        if (8'(slot) == aid) pk_own = sts;
        if (slot == p) begin
            pk_prev_ts = sts;
            pk_prev_dist = sdist;
        end
        if (!lst) return;
        consec = (seq == 8'(seq_tab[a] + 8'd1));
        if (consec) begin
            fa = pk_own[31:0] - tx_tab[a][31:0];
            ft = arr[31:0] - arr_tab[a][31:0];
            if (ft == 0) begin
                ratio_tab[a] = '0;
            end else begin
                q = ((64'(fa) << 30) + 64'(ft >> 1)) / 64'(ft);
                ratio_tab[a] = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
            end
        end
        if (a != p && consec && pk_prev_dist != 0 && pk_prev_ts != 0 && ratio_tab[a] != 0) begin
            dd = arr[31:0] - arr_tab[p][31:0];
            delta = 64'(pk_prev_dist) + 64'(32'(pk_own[31:0] - pk_prev_ts[31:0]));
            r.diff = scale_to_metres(dd, ratio_tab[a], delta);
            r.prev_a = 3'(p);
            r.curr_a = 3'(a);
            dist_q.push_back(r);
        end
        arr_tab[a] = arr;
        tx_tab[a] = pk_own;
        seq_tab[a] = seq;
        heard_prev = a;
        pk_own = '0;
        pk_prev_ts = '0;
        pk_prev_dist = '0;
    endtask

    // stimulus generator state
    logic [7:0]  gen_prev = '0;
    logic [7:0]  gen_seq [ANCHOR_COUNT];
    logic [39:0] gen_off [ANCHOR_COUNT];
    logic [39:0] gen_t;

    function automatic logic [39:0] rand40();
        return {8'($urandom), 32'($urandom)};
    endfunction

    task automatic push_slot(input logic [7:0] aid, input logic [7:0] seq, input logic [39:0] arr,
                             input logic [2:0] slot, input logic [39:0] ts,
                             input logic [31:0] sdist, input logic lst);
        slot_word_t w;
        w.data = {5'b0, sdist, ts, slot, arr, seq, aid};
        w.last = lst;
        word_q.push_back(w);
    endtask

    // one anchor packet: extra random slots, then own and previous entries in random order
    task automatic push_packet(input logic [7:0] aid, input logic [7:0] seq, input logic [39:0] arr,
                               input logic [39:0] own_ts, input logic [39:0] prev_ts,
                               input logic [31:0] prev_dist, input bit with_own,
                               input bit with_prev, input int extras);
        int n, k;
        bit own_first;
        n = extras + int'(with_own) + int'(with_prev);
        if (n == 0) begin
            extras = 1;
            n = 1;
        end
        k = 0;
        own_first = $urandom_range(0, 1);
        for (int i = 0; i < extras; i++) begin
            k++;
            push_slot(aid, seq, arr, 3'($urandom), rand40(), $urandom, k == n);
        end
        if (with_own && own_first) begin
            k++;
            push_slot(aid, seq, arr, aid[2:0], own_ts, $urandom, k == n);
        end
        if (with_prev) begin
            k++;
            push_slot(aid, seq, arr, gen_prev[2:0], prev_ts, prev_dist, k == n);
        end
        if (with_own && !own_first) begin
            k++;
            push_slot(aid, seq, arr, aid[2:0], own_ts, $urandom, k == n);
        end
        packets_sent++;
        if (aid < ANCHOR_COUNT) begin
            gen_seq[aid[AW-1:0]] = seq;
            gen_prev = aid;
        end
    endtask

    task automatic push_good_packet(input logic [7:0] aid);
        logic [39:0] own;
        gen_t = gen_t + 40'($urandom_range(1000, 200000));
        own = gen_t + gen_off[aid[AW-1:0]] + 40'($urandom_range(0, 40));
        push_packet(aid, gen_seq[aid[AW-1:0]] + 8'd1, gen_t, own,
                    own - 40'($urandom_range(1, 100000)), $urandom_range(1, 5000), 1'b1, 1'b1,
                    $urandom_range(0, 3));
    endtask

    task automatic build_stimulus();
        logic [7:0] a;
        for (int i = 0; i < ANCHOR_COUNT; i++) begin
            gen_seq[i] = '0;
            gen_off[i] = rand40();
        end
        gen_t = rand40();
        // same anchor as the previous one after reset
        push_packet(8'd0, 8'd1, 40'd1000, 40'd500, 40'd400, 32'd7, 1'b1, 1'b1, 0);
        // ignored anchor id, with a last mark
        push_slot(8'hFF, 8'hFF, '1, 3'h7, '1, '1, 1'b1);
        push_slot(8'd8, 8'd0, '0, 3'h0, '0, '0, 1'b1);
        // ratio overflow then a result with maximum fields
        push_packet(8'd1, 8'd1, 40'd1, '1, 40'd1, '1, 1'b1, 1'b1, 0);
        // zero frame time on anchor 1
        push_packet(8'd1, 8'd2, 40'd1, 40'd9, 40'd1, 32'd3, 1'b1, 1'b1, 0);
        // ratio that rounds to zero
        push_packet(8'd2, 8'd1, 40'hFF_FFFF_FFFF, 40'd0, 40'd1, 32'd1, 1'b1, 1'b1, 0);
        // missing previous slot and missing own slot
        push_packet(8'd3, 8'd1, 40'd5000, 40'd5000, 40'd0, 32'd0, 1'b1, 1'b0, 1);
        push_packet(8'd4, 8'd1, 40'd9000, 40'd0, 40'd100, 32'd50, 1'b0, 1'b1, 0);
        // zero previous distance, sequence break
        push_packet(8'd5, 8'd1, 40'd20000, 40'd20000, 40'd10, 32'd0, 1'b1, 1'b1, 0);
        push_packet(8'd6, 8'd7, 40'd30000, 40'd30000, 40'd10, 32'd9, 1'b1, 1'b1, 0);
        // zero frame time on anchor 7, then a large negative difference
        push_packet(8'd7, 8'd1, 40'hFF_0000_0000, 40'hFFFF_FFFF, 40'd1, 32'd1, 1'b1, 1'b1, 0);
        push_packet(8'd0, 8'd2, 40'hFF_0000_0001, 40'hFFFF_FFFF, 40'd1, '1, 1'b1, 1'b1, 0);
        while (word_q.size() < 1050) begin
            if ($urandom_range(0, 9) < 8) begin
                do a = 8'($urandom_range(0, ANCHOR_COUNT - 1));
                while (a == gen_prev && $urandom_range(0, 7) != 0);
                push_good_packet(a);
            end else begin
                a = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
                push_packet(a, 8'($urandom), rand40(), rand40(),
                            ($urandom_range(0, 3) == 0) ? 40'd0 : rand40(),
                            ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom),
                            $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 4));
            end
        end
    endtask

    // driver: bursts and gaps on the slot channel
    slot_word_t cur_word;
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_word(cur_word.data, cur_word.last);
                words_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (word_q.size() != 0) begin
                    cur_word = word_q.pop_front();
                    s_tdata <= cur_word.data;
                    s_tlast <= cur_word.last;
                    s_tvalid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 20);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls, calm stretches, one long hold-off
    int stall_left = 0;
    int hold_left = 0;
    bit held_once = 0;

    always @(posedge aclk) begin
        logic next_ready;
        dist_res_t w;
        if (m_tvalid && m_tready) begin
            results_seen++;
            if (dist_q.size() == 0) begin
                report("unexpected word", m_tdata, 0);
            end else begin
                w = dist_q.pop_front();
                if (m_tuser !== 1'b1) report("valid_res", m_tuser, 1);
                if (m_tdata[39:0] !== w.diff) report("distance_diff", m_tdata[39:0], w.diff);
                if (m_tdata[42:40] !== w.prev_a) report("prev_anchor", m_tdata[42:40], w.prev_a);
                if (m_tdata[45:43] !== w.curr_a) report("curr_anchor", m_tdata[45:43], w.curr_a);
            end
        end
        if (!held_once && results_seen == 20) begin
            held_once = 1;
            hold_left = 3000;
        end
        if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            next_ready = 1'b0;
        end else begin
            next_ready = 1'b1;
            if ((cycles / 500) % 3 != 0 && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 200);
        end
        m_tready <= next_ready;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        build_stimulus();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        do @(posedge aclk);
        while (word_q.size() != 0 || s_tvalid);
        while (dist_q.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (dist_q.size() != 0) report("results left over", dist_q.size(), 0);
        $display("%0d slot words in %0d packets, %0d distance results checked",
                 words_sent, packets_sent, results_seen);
        $display("included ignored ids, missing slots, ratio edge cases and a long output stall");
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", errors);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
